// File: rtl/gated_nearest_point_matcher_core_assert.svh
// assertion macros used by gnpm_back
// the using module must have clk and rst_n in scope
`ifndef GATED_NEAREST_POINT_MATCHER_CORE_ASSERT_SVH
`define GATED_NEAREST_POINT_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define GNPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GNPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gnpm_pkg.sv
// ----------------------------------------------------------------------------
// gnpm_pkg
// types and constants of the gated nearest point matcher
// ----------------------------------------------------------------------------
package gnpm_pkg;

  localparam int GNPM_MAX_REFS = 256;
  localparam logic [51:0] GNPM_DIST_RESET = 52'd1048576;
  localparam logic [15:0] GNPM_COS_RESET  = 16'd49152;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic {
    CFG_DIST_LIMIT = 1'b0,
    CFG_COS_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               ref_id_valid;
    logic [15:0]        ref_id;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  match_index;
    logic        id_valid;
    logic [15:0] global_id;
    logic [51:0] distance_sq;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               id_valid;
    logic [15:0]        id;
  } queue_item_t;

endpackage

// File: rtl/gnpm_front.sv
// ----------------------------------------------------------------------------
// gnpm_front
// input stage: decodes commands, drops nops and queues the rest for the execution side
// ----------------------------------------------------------------------------
module gnpm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gnpm_pkg::in_item_t     in_data,
  output logic                   q_valid,
  output gnpm_pkg::queue_item_t  q_item,
  input  logic                   q_pop
);
  import gnpm_pkg::*;

  queue_item_t fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  queue_item_t item;

  always_comb begin
    item.op       = OP_CLEAR;
    item.px       = in_data.pos_x;
    item.py       = in_data.pos_y;
    item.pz       = in_data.pos_z;
    item.nx       = in_data.norm_x;
    item.ny       = in_data.norm_y;
    item.nz       = in_data.norm_z;
    item.id_valid = in_data.ref_id_valid;
    item.id       = in_data.ref_id;
    push          = 1'b0;
    unique case (cmd_e'(in_data.command))
      CMD_CLEAR: begin
        item.op = OP_CLEAR;
        push    = in_valid && !in_stall;
      end
      CMD_LOAD: begin
        item.op = OP_LOAD;
        push    = in_valid && !in_stall;
      end
      CMD_QUERY: begin
        item.op = OP_QUERY;
        push    = in_valid && !in_stall;
      end
      CMD_NOP: begin
        push = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

// File: rtl/gnpm_back.sv
// ----------------------------------------------------------------------------
// gnpm_back
// execution side: reference table, pipelined scan and result register
// ----------------------------------------------------------------------------
`include "gated_nearest_point_matcher_core_assert.svh"

module gnpm_back #(
  parameter int MAX_REFS = gnpm_pkg::GNPM_MAX_REFS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  gnpm_pkg::queue_item_t  q_item,
  output logic                   q_pop,
  input  logic [51:0]            dist_limit_sq,
  input  logic [15:0]            cos_sq_limit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gnpm_pkg::out_item_t    out_data
);
  import gnpm_pkg::*;

  localparam int IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CW = $clog2(MAX_REFS + 1);

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [16:0]        gid;
  } ref_entry_t;

  function automatic logic signed [15:0] fix_nz(logic signed [15:0] x, logic signed [15:0] y,
                                                logic signed [15:0] z);
    fix_nz = (x == 16'sd0 && y == 16'sd0 && z == 16'sd0) ? 16'sd16384 : z;
  endfunction

  // control state
  bk_state_e        state_r, state_nxt;
  logic [CW-1:0]    ref_count_r, ref_count_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             rd_en;
  logic             wr_en;
  logic             start;

  // query context
  logic signed [23:0] qpx_r, qpy_r, qpz_r;
  logic signed [15:0] qnx_r, qny_r, qnz_r;

  // running best
  logic [51:0]      best_r;
  logic [IW-1:0]    best_idx_r;
  logic [16:0]      best_gid_r;
  logic             found_r;

  // table
  ref_entry_t       mem [MAX_REFS];
  ref_entry_t       mem_q;
  ref_entry_t       wr_entry;

  // pipeline
  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic [IW-1:0]    s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r, s6_idx_r;
  logic [16:0]      s2_gid_r, s3_gid_r, s4_gid_r, s5_gid_r, s6_gid_r;
  logic signed [24:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic signed [15:0] s2_bx_r, s2_by_r, s2_bz_r;
  logic [48:0]      s3_sx_r, s3_sy_r, s3_sz_r;
  logic signed [31:0] s3_px_r, s3_py_r, s3_pz_r;
  logic [30:0]      s3_ax_r, s3_ay_r, s3_az_r, s3_bx_r, s3_by_r, s3_bz_r;
  logic [51:0]      s4_dsq_r, s5_dsq_r, s6_dsq_r;
  logic signed [33:0] s4_dot_r;
  logic [31:0]      s4_na_r, s4_nb_r;
  logic [63:0]      s5_d2_r, s5_nanb_r;
  logic [79:0]      s6_lhs_r, s6_rhs_r;

  logic signed [24:0] dx_c, dy_c, dz_c;
  logic signed [49:0] sqx_c, sqy_c, sqz_c;
  logic signed [31:0] ax_c, ay_c, az_c, bx_c, by_c, bz_c;
  logic signed [31:0] px_c, py_c, pz_c;
  logic signed [33:0] ndot_c;
  logic [31:0]      absdot_c;
  logic             upd;
  logic             pipe_busy;

  out_item_t        out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign pipe_busy = s1_v_r | s2_v_r | s3_v_r | s4_v_r | s5_v_r | s6_v_r;
  assign upd       = s6_v_r && (s6_dsq_r < best_r) && (s6_lhs_r > s6_rhs_r);

  always_comb begin
    wr_entry.px  = q_item.px;
    wr_entry.py  = q_item.py;
    wr_entry.pz  = q_item.pz;
    wr_entry.nx  = q_item.nx;
    wr_entry.ny  = q_item.ny;
    wr_entry.nz  = q_item.nz;
    wr_entry.gid = {q_item.id_valid, q_item.id};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ref_count_nxt = ref_count_r;
    issue_nxt     = issue_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    start         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_CLEAR: ref_count_nxt = '0;
            OP_LOAD: begin
              if (ref_count_r < CW'(MAX_REFS)) begin
                wr_en         = 1'b1;
                ref_count_nxt = ref_count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              start     = 1'b1;
              issue_nxt = '0;
              state_nxt = (ref_count_r == '0) ? BK_DRAIN : BK_SCAN;
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        rd_en     = 1'b1;
        issue_nxt = issue_r + 1'b1;
        if (issue_nxt == ref_count_r) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = found_r;
          out_data_nxt.match_index = found_r ? 8'(best_idx_r) : 8'd0;
          out_data_nxt.id_valid    = found_r && best_gid_r[16];
          out_data_nxt.global_id   = (found_r && best_gid_r[16]) ? best_gid_r[15:0] : 16'd0;
          out_data_nxt.distance_sq = best_r;
          state_nxt                = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ref_count_r <= '0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_count_r <= ref_count_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= rd_en;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // table port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ref_count_r[IW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[issue_r[IW-1:0]];
    end
  end

  // query context and running best
  always_ff @(posedge clk) begin
    if (start) begin
      qpx_r      <= q_item.px;
      qpy_r      <= q_item.py;
      qpz_r      <= q_item.pz;
      qnx_r      <= q_item.nx;
      qny_r      <= q_item.ny;
      qnz_r      <= fix_nz(q_item.nx, q_item.ny, q_item.nz);
      best_r     <= dist_limit_sq;
      best_idx_r <= '0;
      best_gid_r <= '0;
      found_r    <= 1'b0;
    end else if (upd) begin
      best_r     <= s6_dsq_r;
      best_idx_r <= s6_idx_r;
      best_gid_r <= s6_gid_r;
      found_r    <= 1'b1;
    end
  end

  // stage 1: differences and entry normal
  always_comb begin
    dx_c = 25'(qpx_r) - 25'(mem_q.px);
    dy_c = 25'(qpy_r) - 25'(mem_q.py);
    dz_c = 25'(qpz_r) - 25'(mem_q.pz);
  end

  // stage 2: products
  always_comb begin
    sqx_c = s2_dx_r * s2_dx_r;
    sqy_c = s2_dy_r * s2_dy_r;
    sqz_c = s2_dz_r * s2_dz_r;
    px_c  = qnx_r * s2_bx_r;
    py_c  = qny_r * s2_by_r;
    pz_c  = qnz_r * s2_bz_r;
    ax_c  = qnx_r * qnx_r;
    ay_c  = qny_r * qny_r;
    az_c  = qnz_r * qnz_r;
    bx_c  = s2_bx_r * s2_bx_r;
    by_c  = s2_by_r * s2_by_r;
    bz_c  = s2_bz_r * s2_bz_r;
  end

  // stage 4: magnitude of the dot product
  always_comb begin
    ndot_c   = -s4_dot_r;
    absdot_c = s4_dot_r[33] ? ndot_c[31:0] : s4_dot_r[31:0];
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= issue_r[IW-1:0];

    s2_idx_r  <= s1_idx_r;
    s2_gid_r  <= mem_q.gid;
    s2_dx_r   <= dx_c;
    s2_dy_r   <= dy_c;
    s2_dz_r   <= dz_c;
    s2_bx_r   <= mem_q.nx;
    s2_by_r   <= mem_q.ny;
    s2_bz_r   <= fix_nz(mem_q.nx, mem_q.ny, mem_q.nz);

    s3_idx_r  <= s2_idx_r;
    s3_gid_r  <= s2_gid_r;
    s3_sx_r   <= sqx_c[48:0];
    s3_sy_r   <= sqy_c[48:0];
    s3_sz_r   <= sqz_c[48:0];
    s3_px_r   <= px_c;
    s3_py_r   <= py_c;
    s3_pz_r   <= pz_c;
    s3_ax_r   <= ax_c[30:0];
    s3_ay_r   <= ay_c[30:0];
    s3_az_r   <= az_c[30:0];
    s3_bx_r   <= bx_c[30:0];
    s3_by_r   <= by_c[30:0];
    s3_bz_r   <= bz_c[30:0];

    s4_idx_r  <= s3_idx_r;
    s4_gid_r  <= s3_gid_r;
    s4_dsq_r  <= 52'(s3_sx_r) + 52'(s3_sy_r) + 52'(s3_sz_r);
    s4_dot_r  <= 34'(s3_px_r) + 34'(s3_py_r) + 34'(s3_pz_r);
    s4_na_r   <= 32'(s3_ax_r) + 32'(s3_ay_r) + 32'(s3_az_r);
    s4_nb_r   <= 32'(s3_bx_r) + 32'(s3_by_r) + 32'(s3_bz_r);

    s5_idx_r  <= s4_idx_r;
    s5_gid_r  <= s4_gid_r;
    s5_dsq_r  <= s4_dsq_r;
    s5_d2_r   <= 64'(absdot_c) * 64'(absdot_c);
    s5_nanb_r <= 64'(s4_na_r) * 64'(s4_nb_r);

    s6_idx_r  <= s5_idx_r;
    s6_gid_r  <= s5_gid_r;
    s6_dsq_r  <= s5_dsq_r;
    s6_lhs_r  <= {s5_d2_r, 16'd0};
    s6_rhs_r  <= 80'(s5_nanb_r) * 80'(cos_sq_limit);
  end

  `GNPM_ASSERT_IMP(a_count_bound, 1'b1, ref_count_r <= CW'(MAX_REFS), "table count overflow")
  `GNPM_ASSERT_IMP(a_issue_range, state_r == BK_SCAN, issue_r < ref_count_r, "scan past table")
  `GNPM_ASSERT_NXT(a_out_from_done, !out_valid_r && state_r != BK_DONE, !out_valid_r, "stray result")
  `GNPM_ASSERT_IMP(a_found_below, out_valid_r && out_data_r.found, out_data_r.distance_sq < dist_limit_sq, "match not below limit")

endmodule

// File: rtl/gated_nearest_point_matcher_core.sv
// ----------------------------------------------------------------------------
// gated_nearest_point_matcher_core
// nearest reference point search with distance and normal angle gating
// ----------------------------------------------------------------------------
//  channel   handshake            payload           direction
//  in        in_valid / in_stall  in_data           command and point in
//  out       out_valid/out_stall  out_data          one result per query
//  cfg       cfg_valid/cfg_ready  cfg_index/wdata   register writes
//
//  a query reads one table entry per cycle from the single read port
//  and then drains the distance/angle pipeline
//  clear and load are handled in the idle state on the execution side
//  rst_n is synchronous; it empties the table and the command queue
//  the two-entry command queue keeps taking beats while a query scans, until it is full
//  a stalled result waits in the output register
// ----------------------------------------------------------------------------
module gated_nearest_point_matcher_core #(
  parameter int MAX_REFS = gnpm_pkg::GNPM_MAX_REFS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gnpm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gnpm_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [51:0]          cfg_wdata
);
  import gnpm_pkg::*;

  // configuration registers
  logic [51:0] dist_limit_r;
  logic [15:0] cos_limit_r;

  // front to back queue
  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_limit_r <= GNPM_DIST_RESET;
      cos_limit_r  <= GNPM_COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_DIST_LIMIT: dist_limit_r <= cfg_wdata;
        CFG_COS_LIMIT:  cos_limit_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // decode and queue commands
  gnpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // table, scan pipeline and result register
  gnpm_back #(
    .MAX_REFS (MAX_REFS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .dist_limit_sq (dist_limit_r),
    .cos_sq_limit  (cos_limit_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
